// ===== rtl/gn2o_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2o_pkg
// Shared constants, step codes and the controller-to-datapath command bundle
// for the fractal gradient noise unit.
// ----------------------------------------------------------------------------
package gn2o_pkg;

    localparam int TABLE_BITS  = 8;
    localparam int MAX_OCTAVES = 8;
    localparam int OCT_BITS    = 3;
    localparam int FRAC_BITS   = 16;
    localparam int CNT_BITS    = 4;
    localparam int STEP_BITS   = 5;

    // lattice coordinate bits kept: cell index above the fraction
    localparam int POS_BITS = FRAC_BITS + TABLE_BITS;

    // per-octave sequencer steps
    localparam logic [STEP_BITS-1:0] ST_P0    = 5'd0;
    localparam logic [STEP_BITS-1:0] ST_P1    = 5'd1;
    localparam logic [STEP_BITS-1:0] ST_H00   = 5'd2;
    localparam logic [STEP_BITS-1:0] ST_H10   = 5'd3;
    localparam logic [STEP_BITS-1:0] ST_H01   = 5'd4;
    localparam logic [STEP_BITS-1:0] ST_H11   = 5'd5;
    localparam logic [STEP_BITS-1:0] ST_HLAST = 5'd6;
    localparam logic [STEP_BITS-1:0] ST_G0    = 5'd7;
    localparam logic [STEP_BITS-1:0] ST_MX0   = 5'd8;
    localparam logic [STEP_BITS-1:0] ST_MY0   = 5'd9;
    localparam logic [STEP_BITS-1:0] ST_D0    = 5'd10;
    localparam logic [STEP_BITS-1:0] ST_MX1   = 5'd11;
    localparam logic [STEP_BITS-1:0] ST_MY1   = 5'd12;
    localparam logic [STEP_BITS-1:0] ST_D1    = 5'd13;
    localparam logic [STEP_BITS-1:0] ST_MX2   = 5'd14;
    localparam logic [STEP_BITS-1:0] ST_MY2   = 5'd15;
    localparam logic [STEP_BITS-1:0] ST_D2    = 5'd16;
    localparam logic [STEP_BITS-1:0] ST_MX3   = 5'd17;
    localparam logic [STEP_BITS-1:0] ST_MY3   = 5'd18;
    localparam logic [STEP_BITS-1:0] ST_D3    = 5'd19;
    localparam logic [STEP_BITS-1:0] ST_FX0   = 5'd20;
    localparam logic [STEP_BITS-1:0] ST_FX1   = 5'd21;
    localparam logic [STEP_BITS-1:0] ST_FX2   = 5'd22;
    localparam logic [STEP_BITS-1:0] ST_FY0   = 5'd23;
    localparam logic [STEP_BITS-1:0] ST_FY1   = 5'd24;
    localparam logic [STEP_BITS-1:0] ST_FY2   = 5'd25;
    localparam logic [STEP_BITS-1:0] ST_BA    = 5'd26;
    localparam logic [STEP_BITS-1:0] ST_BB    = 5'd27;
    localparam logic [STEP_BITS-1:0] ST_BC    = 5'd28;
    localparam logic [STEP_BITS-1:0] ST_BD    = 5'd29;
    localparam logic [STEP_BITS-1:0] ST_ACC   = 5'd30;
    localparam logic [STEP_BITS-1:0] ST_LAST  = ST_ACC;

    typedef struct packed {
        logic                 start;
        logic                 load_wr;
        logic                 step_en;
        logic [STEP_BITS-1:0] step;
        logic [OCT_BITS-1:0]  oct;
        logic                 oct_adv;
        logic                 out_wr;
    } t_cmd;

endpackage

// ===== rtl/gn2o_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2o_ctrl
// Sequencer for the noise unit: handshakes, octave count register, step and
// octave counters, output valid flag.
// ----------------------------------------------------------------------------
module gn2o_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_mode,
    input  logic                        i_cfg_valid,
    input  logic [gn2o_pkg::CNT_BITS-1:0] i_cfg_data,
    input  logic                        i_out_stall,
    output logic                        o_in_stall,
    output logic                        o_cfg_ready,
    output logic                        o_out_valid,
    output gn2o_pkg::t_cmd              o_cmd
);
    import gn2o_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic [OCT_BITS-1:0]  r_oct, n_oct;
    logic [OCT_BITS-1:0]  r_last, n_last;
    logic [CNT_BITS-1:0]  r_oct_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [CNT_BITS-1:0]  clamp_cnt;
    logic                 accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign clamp_cnt   = (r_oct_cnt > CNT_BITS'(MAX_OCTAVES)) ?
                         CNT_BITS'(MAX_OCTAVES) : r_oct_cnt;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_oct       = r_oct;
        n_last      = r_last;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_cmd.oct   = r_oct;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_step      = ST_P0;
                        n_oct       = '0;
                        n_last      = OCT_BITS'(clamp_cnt - CNT_BITS'(1));
                        n_state     = (clamp_cnt == '0) ? S_FIN : S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.step_en = 1'b1;
                if (r_step == ST_LAST) begin
                    n_step = ST_P0;
                    if (r_oct == r_last) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.oct_adv = 1'b1;
                        n_oct         = r_oct + OCT_BITS'(1);
                    end
                end else begin
                    n_step = r_step + STEP_BITS'(1);
                end
            end
            S_FIN: begin
                if (!(r_out_valid && i_out_stall)) begin
                    o_cmd.out_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_wr) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_P0;
            r_oct       <= '0;
            r_last      <= '0;
            r_oct_cnt   <= CNT_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_oct       <= n_oct;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_oct_cnt <= i_cfg_data;
            end
        end
    end

endmodule

// ===== rtl/gn2o_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2o_dpath
// Octave datapath: permutation and gradient tables, one shared multiplier,
// corner dot products, fade curves, blends and the octave accumulator.
// ----------------------------------------------------------------------------
module gn2o_dpath (
    input  logic                             i_clk,
    input  gn2o_pkg::t_cmd                   i_cmd,
    input  logic signed [31:0]               i_x_coord,
    input  logic signed [31:0]               i_y_coord,
    input  logic [gn2o_pkg::TABLE_BITS-1:0]  i_entry_index,
    input  logic [gn2o_pkg::TABLE_BITS-1:0]  i_perm_value,
    input  logic signed [15:0]               i_grad_x_value,
    input  logic signed [15:0]               i_grad_y_value,
    output logic [15:0]                      o_noise_value
);
    import gn2o_pkg::*;

    localparam int DEPTH = 1 << TABLE_BITS;

    // tables
    logic [TABLE_BITS-1:0] perm_mem [DEPTH];
    logic [15:0]           gx_mem   [DEPTH];
    logic [15:0]           gy_mem   [DEPTH];

    logic [TABLE_BITS-1:0] paddr, gaddr;
    logic                  g_re;
    logic [TABLE_BITS-1:0] r_prd;
    logic signed [15:0]    r_gx, r_gy;

    logic [POS_BITS-1:0]   r_xs, r_ys;
    logic [TABLE_BITS-1:0] r_p0, r_p1;
    logic [TABLE_BITS-1:0] r_h [4];
    logic signed [35:0]    r_dot [4];
    logic signed [35:0]    r_acc;
    logic [15:0]           r_a2;
    logic [16:0]           r_wx, r_wy;
    logic signed [35:0]    r_xa, r_xb;
    logic signed [39:0]    r_sum;
    logic [15:0]           r_noise;

    logic signed [35:0]    mul_a;
    logic signed [17:0]    mul_b;
    logic signed [53:0]    r_prod;

    logic [FRAC_BITS-1:0]  fx, fy;
    logic [TABLE_BITS-1:0] cx, cy;
    logic [1:0]            corner;
    logic signed [17:0]    dx, dy;
    logic [21:0]           poly_x, poly_y;
    logic signed [35:0]    noise;
    logic signed [39:0]    noise_ext;
    logic signed [41:0]    total;

    // quadratic factor 6*a2 - 15*a + 10 of the quintic fade, clamped at zero
    function automatic logic [21:0] fade_poly(input logic [15:0] a2, input logic [15:0] a);
        logic signed [22:0] p;
        p = (23'(a2) <<< 2) + (23'(a2) <<< 1) - ((23'(a) <<< 4) - 23'(a)) + 23'sd655360;
        fade_poly = p[22] ? 22'd0 : p[21:0];
    endfunction

    assign fx     = r_xs[FRAC_BITS-1:0];
    assign fy     = r_ys[FRAC_BITS-1:0];
    assign cx     = r_xs[POS_BITS-1:FRAC_BITS];
    assign cy     = r_ys[POS_BITS-1:FRAC_BITS];
    assign dx     = {corner[0] ? 2'b11 : 2'b00, fx};
    assign dy     = {corner[1] ? 2'b11 : 2'b00, fy};
    assign poly_x = fade_poly(r_a2, fx);
    assign poly_y = fade_poly(r_a2, fy);
    assign noise  = r_xa + r_prod[51:16];
    assign noise_ext = {{4{noise[35]}}, noise};
    assign total  = {{2{r_sum[39]}}, r_sum} + 42'sh1_0001_0000;
    assign o_noise_value = r_noise;

    // corner in work for the dot product steps
    always_comb begin
        unique case (i_cmd.step)
            ST_MX1, ST_MY1, ST_D1: corner = 2'd1;
            ST_MX2, ST_MY2, ST_D2: corner = 2'd2;
            ST_MX3, ST_MY3, ST_D3: corner = 2'd3;
            default:               corner = 2'd0;
        endcase
    end

    // step decode: table addresses and multiplier operands
    always_comb begin
        paddr = cx;
        gaddr = r_h[0];
        g_re  = 1'b0;
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.step)
            ST_P0:    paddr = cx;
            ST_P1:    paddr = cx + TABLE_BITS'(1);
            ST_H00:   paddr = r_p0 + cy;
            ST_H10:   paddr = r_p0 + cy + TABLE_BITS'(1);
            ST_H01:   paddr = r_p1 + cy;
            ST_H11:   paddr = r_p1 + cy + TABLE_BITS'(1);
            ST_G0: begin
                gaddr = r_h[0];
                g_re  = 1'b1;
            end
            ST_MX0, ST_MX1, ST_MX2, ST_MX3: begin
                mul_a = 36'(r_gx);
                mul_b = dx;
            end
            ST_MY0, ST_MY1, ST_MY2, ST_MY3: begin
                mul_a = 36'(r_gy);
                mul_b = dy;
            end
            ST_D0, ST_D1, ST_D2: begin
                gaddr = r_h[corner + 2'd1];
                g_re  = 1'b1;
            end
            ST_FX0: begin
                mul_a = {20'd0, fx};
                mul_b = {2'b00, fx};
            end
            ST_FX1: begin
                mul_a = {20'd0, r_prod[31:16]};
                mul_b = {2'b00, fx};
            end
            ST_FX2: begin
                mul_a = {14'd0, poly_x};
                mul_b = {2'b00, r_prod[31:16]};
            end
            ST_FY0: begin
                mul_a = {20'd0, fy};
                mul_b = {2'b00, fy};
            end
            ST_FY1: begin
                mul_a = {20'd0, r_prod[31:16]};
                mul_b = {2'b00, fy};
            end
            ST_FY2: begin
                mul_a = {14'd0, poly_y};
                mul_b = {2'b00, r_prod[31:16]};
            end
            ST_BA: begin
                mul_a = r_dot[1] - r_dot[0];
                mul_b = {1'b0, r_wx};
            end
            ST_BB: begin
                mul_a = r_dot[3] - r_dot[2];
                mul_b = {1'b0, r_wx};
            end
            ST_BD: begin
                mul_a = r_xb - r_xa;
                mul_b = {1'b0, r_wy};
            end
            default: ;
        endcase
    end

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            perm_mem[i_entry_index] <= i_perm_value;
            gx_mem[i_entry_index]   <= i_grad_x_value;
            gy_mem[i_entry_index]   <= i_grad_y_value;
        end
        r_prd <= perm_mem[paddr];
        if (g_re && i_cmd.step_en) begin
            r_gx <= gx_mem[gaddr];
            r_gy <= gy_mem[gaddr];
        end
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_xs  <= i_x_coord[POS_BITS-1:0];
            r_ys  <= i_y_coord[POS_BITS-1:0];
            r_sum <= '0;
        end
        if (i_cmd.oct_adv) begin
            r_xs <= {r_xs[POS_BITS-2:0], 1'b0};
            r_ys <= {r_ys[POS_BITS-2:0], 1'b0};
        end
        if (i_cmd.step_en) begin
            unique case (i_cmd.step)
                ST_P1:    r_p0   <= r_prd;
                ST_H00:   r_p1   <= r_prd;
                ST_H10:   r_h[0] <= r_prd;
                ST_H01:   r_h[2] <= r_prd;
                ST_H11:   r_h[1] <= r_prd;
                ST_HLAST: r_h[3] <= r_prd;
                ST_MY0, ST_MY1, ST_MY2, ST_MY3: r_acc <= 36'(r_prod);
                ST_D0, ST_D1, ST_D2, ST_D3:     r_dot[corner] <= r_acc + 36'(r_prod);
                ST_FX1, ST_FY1: r_a2 <= r_prod[31:16];
                ST_FY0:   r_wx   <= r_prod[32:16];
                ST_BA:    r_wy   <= r_prod[32:16];
                ST_BB:    r_xa   <= r_dot[0] + r_prod[51:16];
                ST_BC:    r_xb   <= r_dot[2] + r_prod[51:16];
                ST_ACC:   r_sum  <= r_sum + (noise_ext >>> i_cmd.oct);
                default: ;
            endcase
        end
        // final map (sum + 2) / 4, rounded, saturated
        if (i_cmd.out_wr) begin
            if (total[41]) begin
                r_noise <= 16'd0;
            end else if (total[40:33] != '0) begin
                r_noise <= 16'hFFFF;
            end else begin
                r_noise <= total[32:17];
            end
        end
    end

endmodule

// ===== rtl/gradient_noise_2d_octaves_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_octaves_unit
// Two-dimensional gradient noise summed over up to 8 octaves, Q0.16 result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): mode 1 writes one entry of the
//   permutation and gradient tables, mode 0 evaluates noise at (x, y) in Q16.16.
//   Output channel (o_out_valid / i_out_stall): one noise value per evaluation.
//   Config channel (i_cfg_valid / o_cfg_ready): octave count, always ready.
// Sequence:
//   A load transaction produces no result and does not stall the input.
//   An evaluation runs the per-octave steps on the shared multiplier and
//   single-port table reads, then maps the sum to the output value; zero
//   octaves gives 32768. The input accepts again once the result has been
//   written, which waits until the output register is free.
//   Octave counts above 8 are run as 8.
// Reset:
//   Octave count returns to 1, the output is emptied; tables are not cleared
//   and must be loaded before evaluation.
// Back pressure:
//   The result sits in an output register; the next transaction is accepted
//   while it waits, and the block holds before writing another result.
// ----------------------------------------------------------------------------
module gradient_noise_2d_octaves_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic [7:0]         i_entry_index,
    input  logic [7:0]         i_perm_value,
    input  logic signed [15:0] i_grad_x_value,
    input  logic signed [15:0] i_grad_y_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_noise_value
);
    import gn2o_pkg::*;

    t_cmd w_cmd;

    // sequencer
    gn2o_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // octave datapath
    gn2o_dpath u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_entry_index  (i_entry_index),
        .i_perm_value   (i_perm_value),
        .i_grad_x_value (i_grad_x_value),
        .i_grad_y_value (i_grad_y_value),
        .o_noise_value  (o_noise_value)
    );

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_wr |-> !(o_out_valid && i_out_stall))
        else $error("result written over a pending result");

    // an evaluation blocks further input while it runs
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_mode) |=> o_in_stall)
        else $error("input not stalled after evaluation start");

    // a load leaves the input unstalled afterwards
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_mode) |=> !o_in_stall)
        else $error("input stalled after table load");

endmodule
